>>> rtl/tape_machine_interpreter_assert.svh
// assertion macros used by the rtl
`ifndef TAPE_MACHINE_INTERPRETER_ASSERT_SVH
`define TAPE_MACHINE_INTERPRETER_ASSERT_SVH

`define TMI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define TMI_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/tmi_pkg.sv
package tmi_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_EXEC    = 2'd2,
    ACT_RESTART = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_RIGHT      = 3'd1,
    ERR_LEFT       = 3'd2,
    ERR_OPEN       = 3'd3,
    ERR_CLOSE      = 3'd4,
    ERR_OVERFLOW   = 3'd5
  } error_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FETCH,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN,
    ST_POP,
    ST_OUT
  } state_e;

  localparam logic [7:0] SYM_RIGHT = 8'h3e;
  localparam logic [7:0] SYM_LEFT  = 8'h3c;
  localparam logic [7:0] SYM_INC   = 8'h2b;
  localparam logic [7:0] SYM_DEC   = 8'h2d;
  localparam logic [7:0] SYM_OUT   = 8'h2e;
  localparam logic [7:0] SYM_IN    = 8'h2c;
  localparam logic [7:0] SYM_OPEN  = 8'h5b;
  localparam logic [7:0] SYM_CLOSE = 8'h5d;

  localparam int unsigned CFG_PROGRAM_LENGTH = 0;

endpackage

>>> rtl/tmi_ram.sv
module tmi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/tape_machine_interpreter.sv
// tape machine interpreter
// s_axis requests carry action on tuser and address and value on tdata; each
// request gives exactly one m_axis result: out_valid on tuser, out_byte,
// halted and error_code on tdata.
// load symbol and append input give their result one cycle after acceptance,
// one request a cycle while the receiver takes results.
// restart clears the tape with one write a cycle, then gives its result; the
// same clearing pass runs after reset, without a result, and no request is
// taken until it ends.
// execute reads the program memory and the tape memory in ST_FETCH and writes
// back in ST_EXEC, which registers the result; a ']' that jumps back gives its
// result from ST_POP after a loop stack memory read. a halted execute skips these.
// an open bracket on a zero cell scans the program memory one symbol at a time,
// reading in ST_SCAN_RD and checking in ST_SCAN, up to the match or ERR_OPEN.
// one request is worked on at a time; the result sits in an output register
// and a new request is taken only once that result is taken or in the cycle
// it is taken, so a stalled receiver stops the block.
// program_length is written at apb byte address 0; reads give it back.
module tape_machine_interpreter
  import tmi_pkg::*;
#(
  parameter int unsigned ProgDepth  = 4096,
  parameter int unsigned TapeDepth  = 32768,
  parameter int unsigned InputDepth = 1024,
  parameter int unsigned StackDepth = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // address[11:0], value[19:12], zero
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_byte[7:0], halted[8], error_code[11:9], zero
  output logic        m_axis_tuser,  // out_valid[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PW = $clog2(ProgDepth);
  localparam int unsigned TW = $clog2(TapeDepth);
  localparam int unsigned IW = $clog2(InputDepth) > 0 ? $clog2(InputDepth) : 1;
  localparam int unsigned SW = $clog2(StackDepth) > 0 ? $clog2(StackDepth) : 1;
  localparam int unsigned ICW = $clog2(InputDepth + 1);
  localparam int unsigned SCW = $clog2(StackDepth + 1);
  localparam int unsigned LW = PW + 1;
  localparam logic [LW-1:0] ProgMax = LW'(ProgDepth);
  localparam logic [TW:0] TapeMax = (TW+1)'(TapeDepth);

  logic [12:0] prog_len_q;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'(CFG_PROGRAM_LENGTH * 4)) ? {19'd0, prog_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= '0;
    end else if (psel && penable && pwrite && paddr == 2'(CFG_PROGRAM_LENGTH * 4)) begin
      prog_len_q <= pwdata[12:0];
    end
  end

  logic [LW-1:0] eff_len;
  always_comb begin
    if (17'(prog_len_q) > 17'(ProgDepth)) begin
      eff_len = ProgMax;
    end else begin
      eff_len = LW'(prog_len_q);
    end
  end

  action_e       act;
  logic [11:0]   in_addr;
  logic [7:0]    in_val;
  assign act     = action_e'(s_axis_tuser);
  assign in_addr = s_axis_tdata[11:0];
  assign in_val  = s_axis_tdata[19:12];

  state_e state_q, state_d;
  logic [LW-1:0]  pc_q, pc_d;
  logic [TW-1:0]  dp_q, dp_d;
  logic [ICW-1:0] icnt_q, icnt_d, ipos_q, ipos_d;
  logic [SCW-1:0] scnt_q, scnt_d;
  logic           halt_q, halt_d;
  error_e         err_q, err_d;
  logic [TW-1:0]  clr_q, clr_d;
  logic [LW-1:0]  scan_q, scan_d;
  logic [LW-1:0]  depth_q, depth_d;
  logic           ov_q, ov_d;
  logic           mval_q, mval_d;
  logic [12:0]    mdata_q, mdata_d;

  logic            pwe;
  logic [PW-1:0]   pwaddr, praddr;
  logic [7:0]      prdata_w;
  logic            twe;
  logic [TW-1:0]   twaddr;
  logic [7:0]      twdata, trdata;
  logic            iwe;
  logic [IW-1:0]   iwaddr, iraddr;
  logic [7:0]      irdata;
  logic            swe;
  logic [SW-1:0]   swaddr, sraddr;
  logic [PW-1:0]   swdata, srdata;

  tmi_ram #(.Width(8), .Depth(ProgDepth)) u_prog (
    .clk_i, .we_i(pwe), .waddr_i(pwaddr), .wdata_i(in_val),
    .raddr_i(praddr), .rdata_o(prdata_w));
  tmi_ram #(.Width(8), .Depth(TapeDepth)) u_tape (
    .clk_i, .we_i(twe), .waddr_i(twaddr), .wdata_i(twdata),
    .raddr_i(dp_q), .rdata_o(trdata));
  tmi_ram #(.Width(8), .Depth(InputDepth)) u_input (
    .clk_i, .we_i(iwe), .waddr_i(iwaddr), .wdata_i(in_val),
    .raddr_i(iraddr), .rdata_o(irdata));
  tmi_ram #(.Width(PW), .Depth(StackDepth)) u_stack (
    .clk_i, .we_i(swe), .waddr_i(swaddr), .wdata_i(swdata),
    .raddr_i(sraddr), .rdata_o(srdata));

  logic out_free;
  assign out_free = !mval_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;

  assign pwaddr = PW'(in_addr);
  assign iwaddr = icnt_q[IW-1:0];
  assign iraddr = ipos_q[IW-1:0];
  assign swaddr = scnt_q[SW-1:0];
  assign swdata = pc_q[PW-1:0];
  assign sraddr = SW'(scnt_q - SCW'(1));

  logic in_avail;
  assign in_avail = (ipos_q < icnt_q);

  function automatic logic [12:0] pack_res(logic v, logic [7:0] b, logic h, error_e e);
    pack_res = {e, h, b, v};
  endfunction

  always_comb begin
    state_d = state_q;
    pc_d = pc_q; dp_d = dp_q; icnt_d = icnt_q; ipos_d = ipos_q; scnt_d = scnt_q;
    halt_d = halt_q; err_d = err_q; clr_d = clr_q; scan_d = scan_q;
    depth_d = depth_q; ov_d = ov_q;
    mval_d = mval_q && !m_axis_tready; mdata_d = mdata_q;
    pwe = 1'b0; praddr = pc_q[PW-1:0];
    twe = 1'b0; twaddr = dp_q; twdata = 8'd0;
    iwe = 1'b0; swe = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          case (act)
            ACT_LOAD: begin
              pwe = (17'(in_addr) < 17'(ProgDepth));
              mval_d = 1'b1; mdata_d = pack_res(1'b0, 8'd0, halt_q, err_q);
            end
            ACT_APPEND: begin
              if (icnt_q < ICW'(InputDepth)) begin
                iwe = 1'b1; icnt_d = icnt_q + ICW'(1);
              end
              mval_d = 1'b1; mdata_d = pack_res(1'b0, 8'd0, halt_q, err_q);
            end
            ACT_EXEC: begin
              if (halt_q) begin
                mval_d = 1'b1; mdata_d = pack_res(1'b0, 8'd0, halt_q, err_q);
              end else if (pc_q >= eff_len) begin
                halt_d = 1'b1;
                mval_d = 1'b1; mdata_d = pack_res(1'b0, 8'd0, 1'b1, err_q);
              end else begin
                state_d = ST_FETCH;
              end
            end
            default: begin
              pc_d = '0; dp_d = '0; ipos_d = '0; scnt_d = '0;
              halt_d = 1'b0; err_d = ERR_NONE; clr_d = '0; ov_d = 1'b1;
              state_d = ST_CLEAR;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        twe = 1'b1; twaddr = clr_q; twdata = 8'd0;
        clr_d = clr_q + TW'(1);
        if (clr_q == TW'(TapeDepth - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          if (ov_q) begin
            mval_d = 1'b1; mdata_d = pack_res(1'b0, 8'd0, halt_q, err_q);
          end
          ov_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      ST_FETCH: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        logic [LW-1:0] nxt;
        logic emit;
        nxt = pc_q + LW'(1);
        emit = 1'b0;
        case (prdata_w)
          SYM_RIGHT: begin
            if ({1'b0, dp_q} + (TW+1)'(1) >= TapeMax) begin
              halt_d = 1'b1; err_d = ERR_RIGHT; nxt = pc_q;
            end else begin
              dp_d = dp_q + TW'(1);
            end
          end
          SYM_LEFT: begin
            if (dp_q == '0) begin
              halt_d = 1'b1; err_d = ERR_LEFT; nxt = pc_q;
            end else begin
              dp_d = dp_q - TW'(1);
            end
          end
          SYM_INC: begin
            twe = 1'b1; twdata = trdata + 8'd1;
          end
          SYM_DEC: begin
            twe = 1'b1; twdata = trdata - 8'd1;
          end
          SYM_OUT: begin
            emit = 1'b1;
          end
          SYM_IN: begin
            twe = 1'b1;
            twdata = in_avail ? irdata : 8'd0;
            if (in_avail) ipos_d = ipos_q + ICW'(1);
          end
          SYM_OPEN: begin
            if (trdata == 8'd0) begin
              scan_d = pc_q + LW'(1); depth_d = LW'(1);
              nxt = pc_q;
            end else if (scnt_q >= SCW'(StackDepth)) begin
              halt_d = 1'b1; err_d = ERR_OVERFLOW; nxt = pc_q;
            end else begin
              swe = 1'b1; scnt_d = scnt_q + SCW'(1);
            end
          end
          SYM_CLOSE: begin
            if (scnt_q == '0) begin
              halt_d = 1'b1; err_d = ERR_CLOSE; nxt = pc_q;
            end else if (trdata == 8'd0) begin
              scnt_d = scnt_q - SCW'(1);
            end else begin
              nxt = pc_q;
            end
          end
          default: begin
          end
        endcase
        if (prdata_w == SYM_OPEN && trdata == 8'd0) begin
          state_d = ST_SCAN_RD;
        end else if (prdata_w == SYM_CLOSE && scnt_q != '0 && trdata != 8'd0) begin
          state_d = ST_POP;
        end else begin
          pc_d = nxt;
          if (!(halt_d && err_d != ERR_NONE) && nxt >= eff_len) halt_d = 1'b1;
          mdata_d = pack_res(emit, emit ? trdata : 8'd0, halt_d, err_d);
          mval_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        if (scan_q >= eff_len) begin
          halt_d = 1'b1; err_d = ERR_OPEN;
          mval_d = 1'b1; mdata_d = pack_res(1'b0, 8'd0, 1'b1, ERR_OPEN);
          state_d = ST_IDLE;
        end else begin
          praddr = scan_q[PW-1:0];
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        state_d = ST_SCAN_RD;
        scan_d = scan_q + LW'(1);
        if (prdata_w == SYM_OPEN) begin
          depth_d = depth_q + LW'(1);
        end else if (prdata_w == SYM_CLOSE) begin
          depth_d = depth_q - LW'(1);
          if (depth_q == LW'(1)) begin
            pc_d = scan_q + LW'(1);
            if (scan_q + LW'(1) >= eff_len) halt_d = 1'b1;
            mval_d = 1'b1;
            mdata_d = pack_res(1'b0, 8'd0, scan_q + LW'(1) >= eff_len, err_q);
            state_d = ST_IDLE;
          end
        end
      end
      ST_POP: begin
        pc_d = LW'(srdata) + LW'(1);
        if (LW'(srdata) + LW'(1) >= eff_len) halt_d = 1'b1;
        mval_d = 1'b1;
        mdata_d = pack_res(1'b0, 8'd0, LW'(srdata) + LW'(1) >= eff_len, err_q);
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      pc_q <= '0; dp_q <= '0; icnt_q <= '0; ipos_q <= '0; scnt_q <= '0;
      halt_q <= 1'b0; err_q <= ERR_NONE; clr_q <= '0; scan_q <= '0;
      depth_q <= '0; ov_q <= 1'b0;
      mval_q <= 1'b0; mdata_q <= '0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d; dp_q <= dp_d; icnt_q <= icnt_d; ipos_q <= ipos_d;
      scnt_q <= scnt_d; halt_q <= halt_d; err_q <= err_d; clr_q <= clr_d;
      scan_q <= scan_d; depth_q <= depth_d; ov_q <= ov_d;
      mval_q <= mval_d; mdata_q <= mdata_d;
    end
  end

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = {4'd0, mdata_q[12:1]};
  assign m_axis_tuser  = mdata_q[0];

`include "tape_machine_interpreter_assert.svh"

  `TMI_ASSERT(a_err_halts, (err_q != ERR_NONE) |-> halt_q, "error without halt")
  `TMI_ASSERT(a_stack_bound, scnt_q <= SCW'(StackDepth), "stack count beyond depth")
  `TMI_ASSERT(a_ipos_bound, ipos_q <= icnt_q, "input read beyond count")
  `TMI_ASSERT_NEVER(a_no_take_busy, s_axis_tready && state_q != ST_IDLE, "ready while busy")

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import tmi_pkg::*;

  typedef struct packed {
    logic [2:0] code;
    logic       halt;
    logic [7:0] ob;
    logic       ov;
  } step_out_t;

  typedef struct {
    bit          set_len;
    logic [12:0] len;
    action_e     act;
    logic [11:0] addr;
    logic [7:0]  val;
    bit          typed;
    step_out_t   want;
  } script_row_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tape_machine_interpreter dut (.*);

  always #10 clk_i = ~clk_i;

  // shadow machine state
  logic [7:0]  prog_mem [4096];
  logic [7:0]  tape [32768];
  logic [7:0]  in_bytes [1024];
  logic [11:0] loop_pos [64];
  int unsigned in_cnt, in_pos, pc, dp, sp, prog_len;
  bit          halted;
  error_e      err;

  step_out_t pending_out[$];
  int unsigned mismatches, n_req, n_res, n_bytes, stall_left;

  function automatic step_out_t interpret(action_e a, logic [11:0] ad, logic [7:0] v);
    step_out_t r;
    int unsigned len, nx, d, i;
    bit found;
    error_e fail;
    r = '0;
    fail = ERR_NONE;
    case (a)
      ACT_LOAD: prog_mem[ad] = v;
      ACT_APPEND: if (in_cnt < 1024) begin
        in_bytes[in_cnt] = v;
        in_cnt++;
      end
      ACT_RESTART: begin
        foreach (tape[k]) tape[k] = 8'd0;
        in_pos = 0; pc = 0; dp = 0; sp = 0; halted = 0; err = ERR_NONE;
      end
      default: if (!halted) begin
        len = (prog_len > 4096) ? 4096 : prog_len;
        if (pc >= len) begin
          halted = 1;
        end else begin
          nx = pc + 1;
          case (prog_mem[pc])
            SYM_RIGHT: if (dp == 32767) fail = ERR_RIGHT; else dp++;
            SYM_LEFT: if (dp == 0) fail = ERR_LEFT; else dp--;
            SYM_INC: tape[dp] = tape[dp] + 8'd1;
            SYM_DEC: tape[dp] = tape[dp] - 8'd1;
            SYM_OUT: begin
              r.ov = 1;
              r.ob = tape[dp];
            end
            SYM_IN: if (in_pos < in_cnt) begin
              tape[dp] = in_bytes[in_pos];
              in_pos++;
            end else begin
              tape[dp] = 8'd0;
            end
            SYM_OPEN: if (tape[dp] == 0) begin
              d = 1;
              found = 0;
              for (i = pc + 1; i < len && !found; i++) begin
                if (prog_mem[i] == SYM_OPEN) d++;
                else if (prog_mem[i] == SYM_CLOSE) begin
                  d--;
                  if (d == 0) begin
                    found = 1;
                    nx = i + 1;
                  end
                end
              end
              if (!found) fail = ERR_OPEN;
            end else if (sp >= 64) begin
              fail = ERR_OVERFLOW;
            end else begin
              loop_pos[sp] = pc;
              sp++;
            end
            SYM_CLOSE: if (sp == 0) fail = ERR_CLOSE;
            else if (tape[dp] != 0) nx = loop_pos[sp-1] + 1;
            else sp--;
            default: ;
          endcase
          if (fail != ERR_NONE) begin
            halted = 1;
            err = fail;
            r.ov = 0;
          end else begin
            pc = nx;
            if (nx >= len) halted = 1;
          end
        end
      end
    endcase
    r.halt = halted;
    r.code = err;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send(action_e a, logic [11:0] ad, logic [7:0] v,
                      bit typed = 0, step_out_t want = '0);
    int unsigned gap;
    step_out_t exp_out;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= a;
    s_axis_tdata <= {4'b0000, v, ad};
    do @(posedge clk_i); while (!s_axis_tready);
    exp_out = interpret(a, ad, v);
    pending_out.push_back(typed ? want : exp_out);
    n_req++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_length(logic [12:0] len);
    drain();
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= 2'(CFG_PROGRAM_LENGTH * 4); pwdata <= 32'(len);
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    prog_len = len;
  endtask

  task automatic run_to_halt(int unsigned cap);
    int unsigned n;
    n = 0;
    while (!halted && n < cap) begin
      send(ACT_EXEC, 12'($urandom), 8'($urandom));
      n++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    step_out_t w, got;
    if (!rst_ni) begin
      m_axis_tready <= 0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[11:0], m_axis_tuser};
        n_res++;
        if (got.ov) n_bytes++;
        if (pending_out.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          mismatches++;
        end else begin
          w = pending_out.pop_front();
          if (got.ov !== w.ov) begin
            $display("%0t: out_valid exp %0d got %0d", $time, w.ov, got.ov);
            mismatches++;
          end
          if (got.ob !== w.ob) begin
            $display("%0t: out_byte exp %h got %h", $time, w.ob, got.ob);
            mismatches++;
          end
          if (got.halt !== w.halt) begin
            $display("%0t: halted exp %0d got %0d", $time, w.halt, got.halt);
            mismatches++;
          end
          if (got.code !== w.code) begin
            $display("%0t: error_code exp %0d got %0d", $time, w.code, got.code);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 30);
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  script_row_t script [26] = '{
    '{0, 0, ACT_EXEC, 0, 0, 1, '{ERR_NONE, 1, 0, 0}},
    '{0, 0, ACT_RESTART, 0, 0, 1, '{ERR_NONE, 0, 0, 0}},
    '{1, 13'd8191, ACT_EXEC, 0, 0, 0, '0},
    '{0, 0, ACT_LOAD, 0, SYM_LEFT, 1, '{ERR_NONE, 0, 0, 0}},
    '{0, 0, ACT_EXEC, 0, 0, 1, '{ERR_LEFT, 1, 0, 0}},
    '{0, 0, ACT_EXEC, 0, 0, 1, '{ERR_LEFT, 1, 0, 0}},
    '{0, 0, ACT_RESTART, 0, 0, 1, '{ERR_NONE, 0, 0, 0}},
    '{0, 0, ACT_LOAD, 0, SYM_CLOSE, 0, '0},
    '{0, 0, ACT_EXEC, 0, 0, 1, '{ERR_CLOSE, 1, 0, 0}},
    '{0, 0, ACT_RESTART, 0, 0, 1, '{ERR_NONE, 0, 0, 0}},
    '{1, 13'd16, ACT_EXEC, 0, 0, 0, '0},
    '{0, 0, ACT_LOAD, 0, SYM_OPEN, 0, '0},
    '{0, 0, ACT_EXEC, 0, 0, 1, '{ERR_OPEN, 1, 0, 0}},
    '{0, 0, ACT_RESTART, 0, 0, 1, '{ERR_NONE, 0, 0, 0}},
    '{1, 13'd3, ACT_EXEC, 0, 0, 0, '0},
    '{0, 0, ACT_LOAD, 0, SYM_IN, 0, '0},
    '{0, 0, ACT_APPEND, 12'hfff, 8'hff, 0, '0},
    '{0, 0, ACT_LOAD, 1, SYM_OUT, 0, '0},
    '{0, 0, ACT_LOAD, 2, SYM_DEC, 0, '0},
    '{0, 0, ACT_EXEC, 0, 0, 0, '0},
    '{0, 0, ACT_EXEC, 0, 0, 1, '{ERR_NONE, 0, 8'hff, 1}},
    '{0, 0, ACT_EXEC, 0, 0, 1, '{ERR_NONE, 1, 0, 0}},
    '{0, 0, ACT_EXEC, 0, 0, 1, '{ERR_NONE, 1, 0, 0}},
    '{1, 13'd0, ACT_EXEC, 0, 0, 0, '0},
    '{0, 0, ACT_RESTART, 0, 0, 1, '{ERR_NONE, 0, 0, 0}},
    '{0, 0, ACT_EXEC, 0, 0, 1, '{ERR_NONE, 1, 0, 0}}
  };

  logic [7:0] sym_pool [9] = '{SYM_RIGHT, SYM_LEFT, SYM_INC, SYM_DEC, SYM_OUT,
                               SYM_IN, SYM_OPEN, SYM_CLOSE, 8'h20};

  initial begin
    int unsigned len, depth, k, r;
    logic [7:0] s;
    foreach (tape[i]) tape[i] = 8'd0;
    in_cnt = 0; in_pos = 0; pc = 0; dp = 0; sp = 0; prog_len = 0;
    halted = 0; err = ERR_NONE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;

    // program head written, so no execute reads an unwritten symbol
    for (k = 0; k < 16; k++)
      send(ACT_LOAD, 12'(k), ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h20);
    for (k = 0; k < 16; k++)
      if (prog_mem[k] inside {SYM_RIGHT, SYM_LEFT, SYM_INC, SYM_DEC, SYM_OUT,
                              SYM_IN, SYM_OPEN, SYM_CLOSE})
        send(ACT_LOAD, 12'(k), 8'h20);

    foreach (script[i]) begin
      if (script[i].set_len) set_length(script[i].len);
      else send(script[i].act, script[i].addr, script[i].val,
                script[i].typed, script[i].want);
    end

    // loop stack overflow
    set_length(13'd70);
    send(ACT_LOAD, 0, SYM_INC);
    for (k = 1; k < 70; k++) send(ACT_LOAD, 12'(k), SYM_OPEN);
    send(ACT_RESTART, 0, 0);
    run_to_halt(200);

    // random programs, mostly bracket balanced
    for (int ep = 0; ep < 6; ep++) begin
      len = $urandom_range(4, 40);
      set_length(13'(len));
      depth = 0;
      for (k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (k == 0) s = SYM_INC;
        else if (r < 5) s = 8'($urandom);
        else if (r < 12) s = sym_pool[$urandom_range(0, 8)];
        else if (depth > 0 && len - k <= depth) s = SYM_CLOSE;
        else begin
          s = sym_pool[$urandom_range(0, 8)];
          if (s == SYM_LEFT && r < 70) s = SYM_RIGHT;
          if (s == SYM_CLOSE && depth == 0) s = SYM_DEC;
        end
        if (s == SYM_OPEN) depth++;
        if (s == SYM_CLOSE && depth > 0) depth--;
        send(ACT_LOAD, 12'(k), s);
        if ($urandom_range(0, 9) == 0) send(ACT_APPEND, 0, 8'($urandom));
      end
      send(ACT_RESTART, 12'($urandom), 8'($urandom));
      for (k = 0; k < 60 && !halted; k++) begin
        r = $urandom_range(0, 19);
        if (r == 0) send(ACT_APPEND, 12'($urandom), 8'($urandom));
        else if (r == 1) send(ACT_LOAD, 12'($urandom_range(len, 4095)), 8'h20);
        else send(ACT_EXEC, 12'($urandom), 8'($urandom));
      end
      send(ACT_EXEC, 0, 0);
    end

    s_axis_tvalid <= 0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("ran %0d requests through load, append, execute and restart", n_req);
    $display("checked %0d results, %0d of them with an output byte", n_res, n_bytes);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout with %0d results outstanding", pending_out.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
